// ----- rtl/core/convolutional_byte_deinterleaver_assert.svh -----
// assertion macros shared by the deinterleaver modules
`ifndef CONVOLUTIONAL_BYTE_DEINTERLEAVER_ASSERT_SVH
`define CONVOLUTIONAL_BYTE_DEINTERLEAVER_ASSERT_SVH

// same-cycle implication, checked out of reset
`define CBD_ASSERT_NOW(lbl, clk_s, rst_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) \
    else $error("deinterleaver check failed: same-cycle implication");

// next-cycle implication, checked out of reset
`define CBD_ASSERT_NEXT(lbl, clk_s, rst_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |=> (cons)) \
    else $error("deinterleaver check failed: next-cycle implication");

`endif

// ----- rtl/core/cbdi_pkg.sv -----
package cbdi_pkg;

  // width of one stream byte
  localparam int DATA_W = 8;

  typedef logic [DATA_W-1:0] byte_t;

endpackage

// ----- rtl/core/cbdi_store.sv -----
module cbdi_store import cbdi_pkg::*; #(
  parameter int DEPTH = 1122,
  parameter int AW    = 11
) (
  input  logic          clk,
  input  logic          en,
  input  logic [AW-1:0] addr,
  input  byte_t         wdata,
  output byte_t         rdata
);

  byte_t mem [DEPTH];

  // read-first single port: old byte out, new byte in, same entry
  always_ff @(posedge clk) begin
    if (en) begin
      rdata     <= mem[addr];
      mem[addr] <= wdata;
    end
  end

endmodule

// ----- rtl/core/cbdi_ctrl.sv -----
`include "convolutional_byte_deinterleaver_assert.svh"

module cbdi_ctrl import cbdi_pkg::*; #(
  parameter int BRANCHES   = 12,
  parameter int UNIT_DEPTH = 17,
  parameter int AW         = 11,
  parameter int PW         = 8,
  parameter int BW         = 4
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          step,
  input  logic          frame_start,
  output logic [AW-1:0] addr,
  output logic          bypass
);

  logic [AW-1:0] base_tab [BRANCHES];
  logic [PW-1:0] last_tab [BRANCHES];
  logic [PW-1:0] pos [BRANCHES];
  logic [BW-1:0] commutator;
  logic [BW-1:0] branch;
  logic [BW-1:0] commutator_next;
  logic [PW-1:0] pos_cur;
  logic [PW-1:0] pos_next;

  // per-branch start offset and last pointer value, fixed at elaboration
  for (genvar j = 0; j < BRANCHES; j++) begin : g_tab
    localparam int LEN  = UNIT_DEPTH * (BRANCHES - 1 - j);
    localparam int BASE = UNIT_DEPTH * ((j * (2 * BRANCHES - 1 - j)) / 2);
    if (LEN > 0) begin : g_fifo
      assign base_tab[j] = AW'(BASE);
      assign last_tab[j] = PW'(LEN - 1);
    end else begin : g_pass
      assign base_tab[j] = '0;
      assign last_tab[j] = '0;
    end
  end

  // branch select and entry address for the word on the input
  always_comb begin
    branch          = frame_start ? '0 : commutator;
    bypass          = (branch == BW'(BRANCHES - 1));
    pos_cur         = pos[branch];
    addr            = base_tab[branch] + AW'(pos_cur);
    pos_next        = (pos_cur == last_tab[branch]) ? '0 : pos_cur + PW'(1);
    commutator_next = bypass ? '0 : branch + BW'(1);
  end

  // commutator and branch pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      commutator <= '0;
      for (int k = 0; k < BRANCHES; k++) begin
        pos[k] <= '0;
      end
    end else if (step) begin
      commutator <= commutator_next;
      if (!bypass) begin
        pos[branch] <= pos_next;
      end
    end
  end

  `CBD_ASSERT_NOW(a_comm_range, clk, rst, 1'b1, commutator <= BW'(BRANCHES - 1))
  `CBD_ASSERT_NEXT(a_realign, clk, rst, step && frame_start, commutator == BW'(1))
  `CBD_ASSERT_NEXT(a_pass_ptr, clk, rst, 1'b1, pos[BRANCHES-1] == '0)

endmodule

// ----- rtl/core/convolutional_byte_deinterleaver.sv -----
// Forney convolutional byte deinterleaver (DVB-T style, BRANCHES branches of
// UNIT_DEPTH*(BRANCHES-1-j) bytes). Takes one word per clock and gives one word
// per clock while in_stall and out_stall stay low; an accepted word passes the
// access stage and then the output register. The rate is set by the single
// read-first port of the delay memory: each delayed byte does one read and one
// write of the same entry in its accept cycle. After reset the memory is zeroed
// by a clearing pass over all UNIT_DEPTH*BRANCHES*(BRANCHES-1)/2 entries (1122
// at the defaults) during which in_stall is high. frame_start on an input word
// sends it to branch 0 and realigns the commutator; stored bytes are kept.
`include "convolutional_byte_deinterleaver_assert.svh"

module convolutional_byte_deinterleaver import cbdi_pkg::*; #(
  parameter int BRANCHES   = 12,
  parameter int UNIT_DEPTH = 17
) (
  input  logic  clk,
  input  logic  rst,
  input  byte_t data_in,
  input  logic  frame_start,
  input  logic  in_valid,
  output logic  in_stall,
  output byte_t data_out,
  output logic  out_valid,
  input  logic  out_stall
);

  localparam int STORE_SIZE = UNIT_DEPTH * BRANCHES * (BRANCHES - 1) / 2;
  localparam int MAX_LEN    = UNIT_DEPTH * (BRANCHES - 1);
  localparam int AW         = (STORE_SIZE > 1) ? $clog2(STORE_SIZE) : 1;
  localparam int PW         = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int BW         = $clog2(BRANCHES);

  logic          in_accept;
  logic          s1_move;
  logic          s1_valid;
  logic          s1_bypass;
  byte_t         s1_byte;
  logic          clearing;
  logic [AW-1:0] clr_addr;
  logic [AW-1:0] acc_addr;
  logic          acc_bypass;
  logic          ram_en;
  logic [AW-1:0] ram_addr;
  byte_t         ram_wdata;
  byte_t         ram_q;

  // handshake
  assign in_accept = in_valid && !in_stall;
  assign s1_move   = s1_valid && (!out_valid || !out_stall);
  assign in_stall  = clearing || (s1_valid && !s1_move);

  cbdi_ctrl #(
    .BRANCHES   (BRANCHES),
    .UNIT_DEPTH (UNIT_DEPTH),
    .AW         (AW),
    .PW         (PW),
    .BW         (BW)
  ) u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .step        (in_accept),
    .frame_start (frame_start),
    .addr        (acc_addr),
    .bypass      (acc_bypass)
  );

  // memory port: clearing pass or branch access
  assign ram_en    = clearing || (in_accept && !acc_bypass);
  assign ram_addr  = clearing ? clr_addr : acc_addr;
  assign ram_wdata = clearing ? '0 : data_in;

  cbdi_store #(
    .DEPTH (STORE_SIZE),
    .AW    (AW)
  ) u_store (
    .clk   (clk),
    .en    (ram_en),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_q)
  );

  // control: clearing pass, access stage, output register
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing  <= 1'b1;
      clr_addr  <= '0;
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (clearing) begin
        if (clr_addr == AW'(STORE_SIZE - 1)) begin
          clearing <= 1'b0;
        end
        clr_addr <= clr_addr + AW'(1);
      end
      if (in_accept) begin
        s1_valid <= 1'b1;
      end else if (s1_move) begin
        s1_valid <= 1'b0;
      end
      if (s1_move) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_bypass <= acc_bypass;
      s1_byte   <= data_in;
    end
    if (s1_move) begin
      data_out <= s1_bypass ? s1_byte : ram_q;
    end
  end

  `CBD_ASSERT_NOW(a_no_accept_clear, clk, rst, clearing, !in_accept)
  `CBD_ASSERT_NEXT(a_s1_hold, clk, rst, s1_valid && out_valid && out_stall,
                   s1_valid && $stable(ram_q))
  `CBD_ASSERT_NEXT(a_accept_fills, clk, rst, in_accept, s1_valid)

endmodule

// ----- test/tb.sv -----
module tb;
  import cbdi_pkg::*;

  localparam int BRANCHES    = 12;
  localparam int UNIT_DEPTH  = 17;
  localparam int STORE_DEPTH = UNIT_DEPTH * BRANCHES * (BRANCHES - 1) / 2;
  localparam int LONGEST     = UNIT_DEPTH * (BRANCHES - 1);
  localparam int RANDOM_WORDS = 1900;
  localparam int PACKET_LEN  = 204;
  localparam int DRAIN_TAIL  = 16;
  localparam int CYCLE_LIMIT = 400000;
  localparam int STIM_MAX    = 32;
  localparam int EXP_DEPTH   = 64;

  typedef enum logic [1:0] {
    STALL_NONE,
    STALL_LIGHT,
    STALL_BURST,
    STALL_HEAVY
  } stall_mode_t;

  // one row of the directed stimulus
  typedef struct packed {
    byte_t data;
    logic  realign;
    logic  known;
    byte_t want;
  } stim_row_t;

  logic  clk = 1'b0;
  logic  rst = 1'b1;
  byte_t data_in = '0;
  logic  frame_start = 1'b0;
  logic  in_valid = 1'b0;
  logic  in_stall;
  byte_t data_out;
  logic  out_valid;
  logic  out_stall = 1'b0;

  convolutional_byte_deinterleaver #(
    .BRANCHES  (BRANCHES),
    .UNIT_DEPTH(UNIT_DEPTH)
  ) u_top (
    .clk        (clk),
    .rst        (rst),
    .data_in    (data_in),
    .frame_start(frame_start),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .data_out   (data_out),
    .out_valid  (out_valid),
    .out_stall  (out_stall)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // shadow copy of the deinterleaver state
  byte_t       delay_mem [0:STORE_DEPTH-1];
  int unsigned branch_ptr [0:BRANCHES-1];
  int unsigned next_branch;
  int unsigned branch0_visits;

  // ring of expected words: written by the sender, read by the receiver
  byte_t       exp_store [0:EXP_DEPTH-1];
  int unsigned exp_wr = 0;
  int unsigned exp_rd = 0;

  stim_row_t   stim_rows [0:STIM_MAX-1];
  int unsigned stim_count = 0;

  int unsigned error_count    = 0;
  int unsigned words_in       = 0;
  int unsigned words_out      = 0;
  int unsigned realign_count  = 0;
  int unsigned cycle_count    = 0;
  int unsigned burst_left     = 0;

  task automatic report_error(input string msg);
    $display("ERROR @%0d: %s", cycle_count, msg);
    error_count++;
  endtask

  // byte leaving the branch that this word enters; updates the shadow state
  function automatic byte_t predict_deinterleave(input byte_t d, input logic realign);
    int unsigned br;
    int unsigned len;
    int unsigned base;
    int unsigned addr;
    byte_t       leaving;
    br = realign ? 0 : next_branch;
    len = UNIT_DEPTH * (BRANCHES - 1 - br);
    base = 0;
    for (int k = 0; k < br; k++) base += UNIT_DEPTH * (BRANCHES - 1 - k);
    if (br == 0) branch0_visits++;
    if (len == 0) begin
      leaving = d;
    end else begin
      addr = base + branch_ptr[br];
      leaving = delay_mem[addr];
      delay_mem[addr] = d;
      branch_ptr[br] = (branch_ptr[br] + 1 >= len) ? 0 : branch_ptr[br] + 1;
    end
    next_branch = (br + 1 >= BRANCHES) ? 0 : br + 1;
    return leaving;
  endfunction

  // hold the word until it is taken
  task automatic send_word(input byte_t d, input logic realign, output byte_t leaving);
    in_valid <= 1'b1;
    data_in <= d;
    frame_start <= realign;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    leaving = predict_deinterleave(d, realign);
    words_in++;
    if (realign) realign_count++;
  endtask

  // log a word the receiver must see next
  task automatic queue_expected(input byte_t b);
    exp_store[exp_wr % EXP_DEPTH] = b;
    exp_wr++;
  endtask

  // sender bursts: random length, random gaps, now and then a long unbroken run
  task automatic pace_sender;
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(200, 400)
                                              : $urandom_range(1, 40);
    end else begin
      burst_left--;
    end
  endtask

  task automatic wait_drained;
    in_valid <= 1'b0;
    @(posedge clk);
    while (exp_wr != exp_rd) @(posedge clk);
  endtask

  task automatic add_row(input byte_t d, input logic realign, input logic known,
                         input byte_t want);
    stim_row_t row;
    row.data = d;
    row.realign = realign;
    row.known = known;
    row.want = want;
    stim_rows[stim_count] = row;
    stim_count++;
  endtask

  // cycle limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // receiver: check each word taken, then pick the next stall
  always @(posedge clk) begin : check_output
    byte_t       want;
    stall_mode_t mode;
    if (!rst) begin
      if (out_valid && !out_stall) begin
        if (exp_wr == exp_rd) begin
          report_error($sformatf("unexpected word 0x%02h", data_out));
        end else begin
          want = exp_store[exp_rd % EXP_DEPTH];
          exp_rd++;
          words_out++;
          if (data_out !== want)
            report_error($sformatf("data_out 0x%02h, expected 0x%02h (word %0d)",
                                   data_out, want, words_out));
        end
      end
      mode = stall_mode_t'(cycle_count[9:8] ^ cycle_count[12:11]);
      case (mode)
        STALL_NONE:  out_stall <= 1'b0;
        STALL_LIGHT: out_stall <= ($urandom_range(0, 9) < 3);
        STALL_BURST: out_stall <= (cycle_count[3:0] < 5);
        default:     out_stall <= ($urandom_range(0, 3) != 0);
      endcase
    end
  end

  initial begin : stimulus
    byte_t       leaving;
    byte_t       d;
    logic        realign;
    logic        packet;
    int unsigned seg_len;
    int unsigned sent;
    int unsigned seg_count;

    for (int i = 0; i < STORE_DEPTH; i++) delay_mem[i] = '0;
    for (int j = 0; j < BRANCHES; j++) branch_ptr[j] = 0;
    next_branch = 0;
    branch0_visits = 0;

    // one pass of the commutator from reset: every delayed branch gives zero,
    // the last branch hands its word straight through
    add_row(8'hFF, 1'b0, 1'b1, 8'h00);
    add_row(8'h00, 1'b0, 1'b1, 8'h00);
    add_row(8'h80, 1'b0, 1'b1, 8'h00);
    add_row(8'h01, 1'b0, 1'b1, 8'h00);
    add_row(8'h7F, 1'b0, 1'b1, 8'h00);
    add_row(8'hFE, 1'b0, 1'b1, 8'h00);
    add_row(8'h55, 1'b0, 1'b1, 8'h00);
    add_row(8'hAA, 1'b0, 1'b1, 8'h00);
    add_row(8'h0F, 1'b0, 1'b1, 8'h00);
    add_row(8'hF0, 1'b0, 1'b1, 8'h00);
    add_row(8'h33, 1'b0, 1'b1, 8'h00);
    add_row(8'hA5, 1'b0, 1'b1, 8'hA5);
    // realignment mid-cycle and twice in a row
    add_row(8'h5A, 1'b0, 1'b1, 8'h00);
    add_row(8'h3C, 1'b1, 1'b1, 8'h00);
    add_row(8'hC3, 1'b1, 1'b1, 8'h00);
    add_row(8'h7E, 1'b0, 1'b1, 8'h00);
    add_row(8'hFF, 1'b1, 1'b0, 8'h00);
    // realign then run up to the pass-through branch, then realign on branch 0 itself
    for (int k = 0; k < BRANCHES - 1; k++)
      add_row(8'(8'h10 + k), 1'b0, 1'b0, 8'h00);
    add_row(8'h00, 1'b1, 1'b0, 8'h00);

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // directed part
    for (int i = 0; i < stim_count; i++) begin
      send_word(stim_rows[i].data, stim_rows[i].realign, leaving);
      queue_expected(stim_rows[i].known ? stim_rows[i].want : leaving);
      if ($urandom_range(0, 2) == 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 4)) @(posedge clk);
      end
    end

    // sender holds off until the block has emptied
    wait_drained();

    // random part: mostly aligned packets, the rest short noisy runs
    sent = 0;
    seg_count = 0;
    while (sent < RANDOM_WORDS) begin
      packet = ($urandom_range(0, 9) < 6);
      seg_len = packet ? PACKET_LEN : $urandom_range(1, 60);
      for (int i = 0; i < seg_len; i++) begin
        d = byte_t'($urandom_range(0, 255));
        realign = packet ? (i == 0) : 1'($urandom_range(0, 1));
        send_word(d, realign, leaving);
        queue_expected(leaving);
        sent++;
        pace_sender();
      end
      seg_count++;
      if (seg_count % 7 == 0) wait_drained();
    end

    wait_drained();
    repeat (DRAIN_TAIL) @(posedge clk);
    if (exp_wr != exp_rd) begin
      report_error($sformatf("%0d expected words never came", exp_wr - exp_rd));
    end

    $display("summary: %0d words in, %0d words out checked, %0d realignments",
             words_in, words_out, realign_count);
    $display("summary: longest branch visited %0d times against a depth of %0d",
             branch0_visits, LONGEST);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
